// ===== design/uahw_pkg.sv =====
// ============================================================================
// uahw_pkg
// Shared types, codes and constants for the tar header walker.
// ============================================================================
package uahw_pkg;

    // Parameter defaults
    localparam int NAME_LEN_DEF    = 32;
    localparam int MAX_ENTRIES_DEF = 64;

    // Header layout
    localparam int       BLOCK_LEN  = 512;
    localparam logic [8:0] HDR_LAST   = 9'd511;
    localparam logic [8:0] SIZE_FIRST = 9'd124;
    localparam logic [8:0] SIZE_LAST  = 9'd135;
    localparam logic [8:0] TYPE_OFF   = 9'd156;

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    // Record kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_ENDED
    } t_phase;

    typedef enum logic [1:0] {
        OCT_SKIP,
        OCT_DIGITS,
        OCT_STOP
    } t_oct;

    typedef enum logic [2:0] {
        ST_WALK,
        ST_PREP1,
        ST_PREP2,
        ST_CHAR,
        ST_END
    } t_state;

    typedef enum logic [1:0] {
        SEL_CHAR,
        SEL_ENTRY,
        SEL_END
    } t_out_sel;

    typedef enum logic [1:0] {
        RD_S,
        RD_P1,
        RD_P2
    } t_rd_mode;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     load;
        t_out_sel sel;
        logic     last;
        t_rd_mode rd_mode;
        logic     prep;
        logic     start;
        logic     adv;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic zero_end;
        logic hdr_emit;
        logic final_end;
        logic char_ok;
        logic end_pend;
    } t_sts;

endpackage

// ===== design/uahw_if.sv =====
// ============================================================================
// uahw_if
// Valid/ready channels for archive bytes in and records out.
// ============================================================================
interface uahw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] archive_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, output archive_byte, output first_byte,
                    output final_byte, input ready);
    modport sink   (input valid, input archive_byte, input first_byte,
                    input final_byte, output ready);
endinterface

interface uahw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [7:0]  name_char;
    logic [6:0]  entry_number;
    logic [35:0] file_size;
    logic        is_directory;
    logic        run_last;

    modport source (output valid, output record_kind, output name_char,
                    output entry_number, output file_size, output is_directory,
                    output run_last, input ready);
    modport sink   (input valid, input record_kind, input name_char,
                    input entry_number, input file_size, input is_directory,
                    input run_last, output ready);
endinterface

// ===== design/uahw_ctrl.sv =====
// ============================================================================
// uahw_ctrl
// Sequencer: takes bytes, then plays out name characters and records.
// ============================================================================
module uahw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  uahw_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output uahw_pkg::t_cmd o_cmd
);
    import uahw_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WALK;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.sel     = SEL_END;
        o_cmd.rd_mode = RD_P1;
        case (r_state)
            ST_WALK: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.zero_end) begin
                        o_cmd.load = 1'b1;
                        o_cmd.sel  = SEL_END;
                        o_cmd.last = 1'b1;
                    end else if (i_sts.hdr_emit) begin
                        n_state = ST_PREP1;
                    end else if (i_sts.final_end) begin
                        o_cmd.load = 1'b1;
                        o_cmd.sel  = SEL_END;
                        o_cmd.last = 1'b1;
                    end
                end
            end
            // fetch the first name byte after prefix stripping
            ST_PREP1: begin
                o_cmd.rd_mode = RD_S;
                o_cmd.prep    = 1'b1;
                n_state       = ST_PREP2;
            end
            ST_PREP2: begin
                o_cmd.rd_mode = RD_P1;
                o_cmd.start   = 1'b1;
                n_state       = ST_CHAR;
            end
            // stream characters, then the entry record
            ST_CHAR: begin
                if (i_sts.char_ok) begin
                    if (i_sts.out_free) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.sel     = SEL_CHAR;
                        o_cmd.adv     = 1'b1;
                        o_cmd.rd_mode = RD_P2;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = SEL_ENTRY;
                    o_cmd.last = !i_sts.end_pend;
                    n_state    = i_sts.end_pend ? ST_END : ST_WALK;
                end
            end
            ST_END: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = SEL_END;
                    o_cmd.last = 1'b1;
                    n_state    = ST_WALK;
                end
            end
            default: begin
                n_state = ST_WALK;
            end
        endcase
    end

endmodule

// ===== design/uahw_datapath.sv =====
// ============================================================================
// uahw_datapath
// Walk state, octal size decode, name store and the output register.
// ============================================================================
module uahw_datapath #(
    parameter int NAME_LEN    = uahw_pkg::NAME_LEN_DEF,
    parameter int MAX_ENTRIES = uahw_pkg::MAX_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_archive_byte,
    input  logic           i_first_byte,
    input  logic           i_final_byte,
    input  logic           i_out_ready,
    input  uahw_pkg::t_cmd i_cmd,
    output uahw_pkg::t_sts o_sts,
    output logic           o_out_valid,
    output logic [1:0]     o_record_kind,
    output logic [7:0]     o_name_char,
    output logic [6:0]     o_entry_number,
    output logic [35:0]    o_file_size,
    output logic           o_is_directory,
    output logic           o_run_last
);
    import uahw_pkg::*;

    localparam int DEPTH = NAME_LEN + 3;
    localparam int IW    = $clog2(DEPTH);
    localparam int AW    = $clog2(NAME_LEN + 5);
    localparam int NW    = $clog2(NAME_LEN);

    // Walk state
    t_phase      r_phase, n_phase;
    logic [8:0]  r_off, n_off;
    logic [36:0] r_skip, n_skip;
    logic [35:0] r_size, n_size;
    t_oct        r_oct, n_oct;
    logic        r_dir, n_dir;
    logic [6:0]  r_cnt, n_cnt;

    // Name store and emit window
    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_b0, r_b1, r_b2;
    logic [7:0]    r_rd_q;
    logic [AW-1:0] r_p;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    r_cur;
    logic [NW-1:0] r_n;
    logic [1:0]    w_s;
    logic [7:0]    w_at_s0;

    // Entry latched at header end
    logic [6:0]  r_ent_num;
    logic [35:0] r_ent_size;
    logic        r_ent_dir;
    logic        r_end_pend;

    // Output register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_char;
    logic [6:0]  r_num;
    logic [35:0] r_osize;
    logic        r_odir;
    logic        r_last;

    // Byte decode against state as seen after a possible restart
    t_phase      eff_phase;
    logic [8:0]  eff_off;
    logic [36:0] eff_skip;
    logic [35:0] eff_size;
    t_oct        eff_oct;
    logic        eff_dir;
    logic [6:0]  eff_cnt;
    logic        w_zero_end;
    logic        w_hdr_done;
    logic        w_hdr_emit;
    logic        w_final_end;
    logic [36:0] w_rounded;
    logic [36:0] w_skip_dec;
    logic        w_out_free;

    always_comb begin
        eff_phase = i_first_byte ? PH_HEADER : r_phase;
        eff_off   = i_first_byte ? 9'd0      : r_off;
        eff_skip  = i_first_byte ? 37'd0     : r_skip;
        eff_size  = i_first_byte ? 36'd0     : r_size;
        eff_oct   = i_first_byte ? OCT_SKIP  : r_oct;
        eff_dir   = i_first_byte ? 1'b0      : r_dir;
        eff_cnt   = i_first_byte ? 7'd0      : r_cnt;
    end

    assign w_zero_end  = (eff_phase == PH_HEADER) && (eff_off == 9'd0) &&
                         (i_archive_byte == CH_NUL);
    assign w_hdr_done  = (eff_phase == PH_HEADER) && (eff_off == HDR_LAST);
    assign w_hdr_emit  = w_hdr_done && (eff_cnt < 7'(MAX_ENTRIES));
    assign w_final_end = i_final_byte && (eff_phase != PH_ENDED) && !w_zero_end;
    assign w_rounded   = ({1'b0, eff_size} + 37'(BLOCK_LEN - 1)) &
                         ~37'(BLOCK_LEN - 1);
    assign w_skip_dec  = (eff_skip != 37'd0) ? eff_skip - 37'd1 : eff_skip;

    // Next walk state for an accepted byte
    always_comb begin
        n_phase = eff_phase;
        n_off   = eff_off;
        n_skip  = eff_skip;
        n_size  = eff_size;
        n_oct   = eff_oct;
        n_dir   = eff_dir;
        n_cnt   = eff_cnt;
        case (eff_phase)
            PH_DATA: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == 37'd0) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (w_zero_end) begin
                    n_phase = PH_ENDED;
                end else begin
                    // octal size: skip blanks, shift digits, stop on anything else
                    if ((eff_off inside {[SIZE_FIRST:SIZE_LAST]}) &&
                        (eff_oct != OCT_STOP)) begin
                        if ((eff_oct == OCT_SKIP) &&
                            (i_archive_byte inside {CH_SPACE, CH_TAB})) begin
                            n_oct = eff_oct;
                        end else if (i_archive_byte inside {[CH_ZERO:CH_SEVEN]}) begin
                            n_size = {eff_size[32:0], i_archive_byte[2:0]};
                            n_oct  = OCT_DIGITS;
                        end else begin
                            n_oct = OCT_STOP;
                        end
                    end
                    if (eff_off == TYPE_OFF) begin
                        n_dir = (i_archive_byte == CH_FIVE);
                    end
                    if (!w_hdr_done) begin
                        n_off = eff_off + 9'd1;
                    end else begin
                        if (w_hdr_emit) begin
                            n_cnt = eff_cnt + 7'd1;
                        end
                        n_skip  = w_rounded;
                        n_phase = (w_rounded != 37'd0) ? PH_DATA : PH_HEADER;
                        n_off   = 9'd0;
                        n_size  = 36'd0;
                        n_oct   = OCT_SKIP;
                        n_dir   = 1'b0;
                    end
                end
            end
            default: begin
                n_phase = eff_phase;
            end
        endcase
        // last byte of the buffer closes the archive
        if (i_final_byte && (n_phase != PH_ENDED)) begin
            n_phase = PH_ENDED;
            n_off   = 9'd0;
            n_size  = 36'd0;
            n_oct   = OCT_SKIP;
            n_dir   = 1'b0;
        end
    end

    // Walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_off   <= 9'd0;
            r_skip  <= 37'd0;
            r_size  <= 36'd0;
            r_oct   <= OCT_SKIP;
            r_dir   <= 1'b0;
            r_cnt   <= 7'd0;
        end else if (i_cmd.accept) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_skip  <= n_skip;
            r_size  <= n_size;
            r_oct   <= n_oct;
            r_dir   <= n_dir;
            r_cnt   <= n_cnt;
        end
    end

    // Latch the entry summary when a header completes
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_hdr_done) begin
            r_ent_num  <= eff_cnt + 7'd1;
            r_ent_size <= eff_size;
            r_ent_dir  <= eff_dir;
            r_end_pend <= i_final_byte;
        end
    end

    // Name store write, with the first three bytes also kept aside
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (eff_phase == PH_HEADER) && !w_zero_end) begin
            if (eff_off < 9'(DEPTH)) begin
                mem[eff_off[IW-1:0]] <= i_archive_byte;
            end
            if (eff_off == 9'd0) begin
                r_b0 <= i_archive_byte;
            end
            if (eff_off == 9'd1) begin
                r_b1 <= i_archive_byte;
            end
            if (eff_off == 9'd2) begin
                r_b2 <= i_archive_byte;
            end
        end
    end

    // Prefix strip: drop "./", then one "/"
    always_comb begin
        w_s     = ((r_b0 == CH_DOT) && (r_b1 == CH_SLASH)) ? 2'd2 : 2'd0;
        w_at_s0 = (w_s == 2'd2) ? r_b2 : r_b0;
        if (w_at_s0 == CH_SLASH) begin
            w_s = w_s + 2'd1;
        end
    end

    // Read address select
    always_comb begin
        case (i_cmd.rd_mode)
            RD_S:    w_rd_addr = AW'(w_s);
            RD_P2:   w_rd_addr = r_p + AW'(2);
            default: w_rd_addr = r_p + AW'(1);
        endcase
    end

    // Registered read, zero past the end of the store
    always_ff @(posedge i_clk) begin
        if (w_rd_addr < AW'(DEPTH)) begin
            r_rd_q <= mem[w_rd_addr[IW-1:0]];
        end else begin
            r_rd_q <= CH_NUL;
        end
    end

    // Emit window: current character, pointer and count
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_p <= AW'(w_s);
        end
        if (i_cmd.start) begin
            r_cur <= r_rd_q;
            r_n   <= '0;
        end
        if (i_cmd.adv) begin
            r_cur <= r_rd_q;
            r_p   <= r_p + AW'(1);
            r_n   <= r_n + NW'(1);
        end
    end

    // Output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_cmd.last;
            case (i_cmd.sel)
                SEL_CHAR: begin
                    r_kind  <= KIND_CHAR;
                    r_char  <= r_cur;
                    r_num   <= 7'd0;
                    r_osize <= 36'd0;
                    r_odir  <= 1'b0;
                end
                SEL_ENTRY: begin
                    r_kind  <= KIND_ENTRY;
                    r_char  <= 8'd0;
                    r_num   <= r_ent_num;
                    r_osize <= r_ent_size;
                    r_odir  <= r_ent_dir;
                end
                default: begin
                    r_kind  <= KIND_END;
                    r_char  <= 8'd0;
                    r_num   <= 7'd0;
                    r_osize <= 36'd0;
                    r_odir  <= 1'b0;
                end
            endcase
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.out_free  = w_out_free;
        o_sts.zero_end  = w_zero_end;
        o_sts.hdr_emit  = w_hdr_emit;
        o_sts.final_end = w_final_end;
        o_sts.char_ok   = (r_n != NW'(NAME_LEN - 1)) && (r_cur != CH_NUL) &&
                          !((r_cur == CH_SLASH) && (r_rd_q == CH_NUL));
        o_sts.end_pend  = r_end_pend;
    end

    assign o_out_valid    = r_out_valid;
    assign o_record_kind  = r_kind;
    assign o_name_char    = r_char;
    assign o_entry_number = r_num;
    assign o_file_size    = r_osize;
    assign o_is_directory = r_odir;
    assign o_run_last     = r_last;

endmodule

// ===== design/ustar_archive_header_walker.sv =====
// ============================================================================
// ustar_archive_header_walker
// Walks a tar archive byte by byte and reports each entry's cleaned name,
// size and directory flag.
// ============================================================================
//
//  Channel   Dir  Payload                                      Handshake
//  i_byte    in   archive_byte, first_byte, final_byte         valid/ready
//  o_rec     out  record_kind, name_char, entry_number,        valid/ready
//                 file_size, is_directory, run_last
//
//  A byte that completes no header is taken whenever the output register is free;
//  such bytes flow back to back. A completed header first sets up the name store
//  read in the PREP1 and PREP2 states, then emits each name character, the entry
//  record and, if the byte was also the last, an end record.
//  A single output register holds a result; input is taken while it drains.
//  Reset is synchronous and clears the walk state and the entry count.
//
module ustar_archive_header_walker #(
    parameter int NAME_LEN    = uahw_pkg::NAME_LEN_DEF,
    parameter int MAX_ENTRIES = uahw_pkg::MAX_ENTRIES_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    uahw_in_if.sink  i_byte,
    uahw_out_if.source o_rec
);
    import uahw_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_in_ready;
    logic        w_out_valid;
    logic [1:0]  w_kind;
    logic [7:0]  w_char;
    logic [6:0]  w_num;
    logic [35:0] w_size;
    logic        w_dir;
    logic        w_last;

    uahw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    uahw_datapath #(
        .NAME_LEN    (NAME_LEN),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_archive_byte (i_byte.archive_byte),
        .i_first_byte   (i_byte.first_byte),
        .i_final_byte   (i_byte.final_byte),
        .i_out_ready    (o_rec.ready),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (w_out_valid),
        .o_record_kind  (w_kind),
        .o_name_char    (w_char),
        .o_entry_number (w_num),
        .o_file_size    (w_size),
        .o_is_directory (w_dir),
        .o_run_last     (w_last)
    );

    assign i_byte.ready       = w_in_ready;
    assign o_rec.valid        = w_out_valid;
    assign o_rec.record_kind  = w_kind;
    assign o_rec.name_char    = w_char;
    assign o_rec.entry_number = w_num;
    assign o_rec.file_size    = w_size;
    assign o_rec.is_directory = w_dir;
    assign o_rec.run_last     = w_last;

    // Never load over a result that is still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> w_sts.out_free)
        else $error("output register overwritten");

    // Advance the name only while emitting a character
    a_adv_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.adv |-> (w_sts.char_ok && w_cmd.load && (w_cmd.sel == SEL_CHAR)))
        else $error("name pointer advanced without a character");

    // An empty header gives an end record right away
    a_zero_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready && w_sts.zero_end) |=>
        (o_rec.valid && (o_rec.record_kind == KIND_END) && o_rec.run_last))
        else $error("missing end record after empty header");

    // A name character never closes a run
    a_char_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec.valid && (o_rec.record_kind == KIND_CHAR)) |-> !o_rec.run_last)
        else $error("name character marked as last");

    // Nothing is offered after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rec.valid)
        else $error("output valid after reset");

endmodule
